@@ rtl/tvr_pkg.sv @@
// Shared types, constants and tile placement for the tile video renderer.
`default_nettype none

package tvr_pkg;

   localparam int TILE_COUNT_DEFAULT = 256;

   localparam int VIDEO_AW     = 11;
   localparam int HALF_AW      = 10;
   localparam int PALETTE_AW   = 7;
   localparam int SET_W        = 5;
   localparam int COL_W        = 5;
   localparam int ROW_W        = 6;
   localparam int PIX_IDX_W    = 6;
   localparam int ADDR_W       = 14;
   localparam int DATA_W       = 16;
   localparam int CODE_W       = 8;

   typedef enum logic [1:0] {
      REQ_VIDEO   = 2'd0,
      REQ_PATTERN = 2'd1,
      REQ_PALETTE = 2'd2
   } req_kind_type;

   // Video store write port.
   typedef struct packed {
      logic                en;
      logic [VIDEO_AW-1:0] addr;
      logic [7:0]          data;
   } video_wr_type;

   // Pattern / palette load request.
   typedef struct packed {
      logic              pat_we;
      logic              pal_we;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } load_type;

   // One tile to draw.
   typedef struct packed {
      logic              start;
      logic [CODE_W-1:0] code;
      logic [SET_W-1:0]  set;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
   } job_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } place_type;

   // Map a folded video address onto the 28x36 grid.
   function automatic place_type place_tile(input logic [HALF_AW-1:0] a);
      place_type            p;
      logic [HALF_AW-1:0]   t;
      p = '0;
      t = '0;
      if (a inside {[10'h002:10'h01d]}) begin
         t     = 10'd29 - a;
         p.col = t[COL_W-1:0];
         p.row = 6'd34;
      end else if (a inside {[10'h022:10'h03d]}) begin
         t     = 10'd61 - a;
         p.col = t[COL_W-1:0];
         p.row = 6'd35;
      end else if (a inside {[10'h040:10'h3bf]}) begin
         t     = a - 10'h040;
         p.col = 5'd27 - t[9:5];
         p.row = 6'd2 + {1'b0, t[4:0]};
      end else if (a inside {[10'h3c2:10'h3df]}) begin
         t     = 10'd27 - (a - 10'h3c2);
         p.col = t[COL_W-1:0];
         p.row = 6'd0;
      end else if (a inside {[10'h3e2:10'h3ff]}) begin
         t     = 10'd27 - (a - 10'h3e2);
         p.col = t[COL_W-1:0];
         p.row = 6'd1;
      end
      return p;
   endfunction

endpackage

`default_nettype wire

@@ rtl/tvr_if.sv @@
// Valid/ready channel interfaces for requests and pixel results.
`default_nettype none

interface tvr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [13:0] addr;
   logic [15:0] data;

   modport source (output valid, output req_type, output addr, output data, input ready);
   modport sink   (input valid, input req_type, input addr, input data, output ready);
endinterface

interface tvr_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  pixel_x;
   logic [8:0]  pixel_y;
   logic [15:0] pixel_colour;
   logic        last;

   modport source (output valid, output pixel_x, output pixel_y, output pixel_colour,
                   output last, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, input pixel_colour,
                   input last, output ready);
endinterface

`default_nettype wire

@@ rtl/tile_video_renderer_unit.sv @@
// Top level of the tile video renderer: request sequencer and store wiring.
`default_nettype none

// Tile video renderer. Requests arrive on req (valid/ready); pixels leave on
// rsp. A pattern or palette load produces nothing and leaves the block idle.
// A video write stores its byte, reads back the tile code and colour byte of
// the tile at that address through the video RAM read port (states RD_CODE,
// RD_SET and CAPTURE), then streams the tile's 64 pixels column by column at
// one pixel per cycle while rsp is ready; the pixel loop does one pattern RAM
// read and one palette RAM read per pixel. Each pixel passes the pattern read
// register and the palette read register before it reaches rsp. A video write
// holds the block, however long rsp is stalled, until the tile's last pixel
// has transferred and the sequencer is idle again; req.ready then comes back.
// After reset the video RAM is cleared one byte per cycle, all 2048 bytes, and
// no request is taken during that pass. Tile codes are reduced modulo
// TILE_COUNT; pattern loads beyond TILE_COUNT*64 and palette loads beyond
// index 127 are dropped, as are requests of the unused type.
module tile_video_renderer_unit #(
   parameter int TILE_COUNT = tvr_pkg::TILE_COUNT_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   tvr_req_if.sink   req,
   tvr_rsp_if.source rsp
);
   import tvr_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_RD_CODE = 5'b00010,
      ST_RD_SET  = 5'b00100,
      ST_CAPTURE = 5'b01000,
      ST_DRAW    = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [HALF_AW-1:0]   fold_ff, fold_in;
   logic [CODE_W-1:0]    code_ff, code_in;

   logic                 clear_busy;
   logic                 engine_busy;
   logic                 accept;
   logic [7:0]           vid_rd_data;
   logic [VIDEO_AW-1:0]  vid_rd_addr;
   video_wr_type         vid_wr;
   load_type             load;
   job_type              job;
   place_type            place;
   logic [15:0]          rem;

   assign req.ready = (state_ff == ST_IDLE) && !clear_busy;
   assign accept    = req.valid && req.ready;

   // video byte is written at the request transfer itself
   assign vid_wr.en   = accept && (req.req_type == REQ_VIDEO);
   assign vid_wr.addr = req.addr[VIDEO_AW-1:0];
   assign vid_wr.data = req.data[7:0];

   assign load.pat_we = accept && (req.req_type == REQ_PATTERN);
   assign load.pal_we = accept && (req.req_type == REQ_PALETTE);
   assign load.addr   = req.addr;
   assign load.data   = req.data;

   // code byte sits in the low half, colour byte in the high half
   assign vid_rd_addr = {(state_ff == ST_RD_SET), fold_ff};

   // tile code modulo TILE_COUNT by restoring subtraction, 8 narrow steps
   always_comb begin
      rem = {8'h00, vid_rd_data};
      for (int k = 7; k >= 0; k--) begin
         if (rem >= (16'(TILE_COUNT) << k)) begin
            rem = rem - (16'(TILE_COUNT) << k);
         end
      end
   end

   assign place = place_tile(fold_ff);

   always_comb begin
      job.start = (state_ff == ST_CAPTURE);
      job.code  = code_ff;
      job.set   = vid_rd_data[SET_W-1:0];
      job.col   = place.col;
      job.row   = place.row;
   end

   always_comb begin
      state_in = state_ff;
      fold_in  = fold_ff;
      code_in  = code_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req.req_type == REQ_VIDEO)) begin
               fold_in  = req.addr[HALF_AW-1:0];
               state_in = ST_RD_CODE;
            end
         end
         ST_RD_CODE: begin
            state_in = ST_RD_SET;
         end
         ST_RD_SET: begin
            code_in  = rem[CODE_W-1:0];
            state_in = ST_CAPTURE;
         end
         ST_CAPTURE: begin
            state_in = ST_DRAW;
         end
         ST_DRAW: begin
            if (!engine_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      fold_ff <= fold_in;
      code_ff <= code_in;
   end

   tvr_video_mem u_video (
      .clock   (clock),
      .reset   (reset),
      .wr      (vid_wr),
      .rd_addr (vid_rd_addr),
      .rd_data (vid_rd_data),
      .busy    (clear_busy)
   );

   tvr_pixel_engine #(
      .TILE_COUNT (TILE_COUNT)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .load  (load),
      .job   (job),
      .busy  (engine_busy),
      .rsp   (rsp)
   );

endmodule

`default_nettype wire

@@ rtl/tvr_video_mem.sv @@
// Video store: 2048 x 8 synchronous RAM with a clearing pass after reset.
`default_nettype none

module tvr_video_mem (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire tvr_pkg::video_wr_type        wr,
   input  wire logic [tvr_pkg::VIDEO_AW-1:0] rd_addr,
   output logic      [7:0]                   rd_data,
   output logic                              busy
);
   import tvr_pkg::*;

   localparam int DEPTH = 1 << VIDEO_AW;

   logic [7:0]          mem [DEPTH];
   logic [7:0]          rd_data_ff;
   logic [VIDEO_AW-1:0] clr_ff, clr_in;
   logic                busy_ff, busy_in;
   logic                we;
   logic [VIDEO_AW-1:0] wa;
   logic [7:0]          wd;

   always_comb begin
      clr_in  = clr_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         clr_in = clr_ff + 1'b1;
         if (&clr_ff) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         clr_ff  <= clr_in;
         busy_ff <= busy_in;
      end
   end

   // clearing pass owns the write port
   assign we = busy_ff | wr.en;
   assign wa = busy_ff ? clr_ff : wr.addr;
   assign wd = busy_ff ? 8'h00 : wr.data;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

`default_nettype wire

@@ rtl/tvr_pixel_engine.sv @@
// Pattern and palette stores plus the per-pixel lookup pipeline.
`default_nettype none

module tvr_pixel_engine #(
   parameter int TILE_COUNT = tvr_pkg::TILE_COUNT_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tvr_pkg::load_type load,
   input  wire tvr_pkg::job_type  job,
   output logic                  busy,
   tvr_rsp_if.source             rsp
);
   import tvr_pkg::*;

   localparam int TILE_W    = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
   localparam int PAT_DEPTH = TILE_COUNT * 64;
   localparam int PAT_AW    = TILE_W + PIX_IDX_W;
   localparam int PAL_DEPTH = 1 << PALETTE_AW;

   logic [1:0]            pat_mem [PAT_DEPTH];
   logic [DATA_W-1:0]     pal_mem [PAL_DEPTH];

   // job registers
   logic [TILE_W-1:0]     code_ff;
   logic [SET_W-1:0]      set_ff;
   logic [COL_W-1:0]      col_ff;
   logic [ROW_W-1:0]      row_ff;

   logic                  busy_ff, busy_in;
   logic                  run_ff, run_in;
   logic [PIX_IDX_W-1:0]  idx_ff, idx_in;
   logic                  v1_ff, v1_in;
   logic [PIX_IDX_W-1:0]  idx1_ff;
   logic [1:0]            pat_q_ff;
   logic                  v2_ff, v2_in;
   logic [DATA_W-1:0]     pal_q_ff;
   logic [7:0]            x_ff;
   logic [8:0]            y_ff;
   logic                  last_ff;

   logic                  advance;
   logic                  pat_hit;
   logic                  pal_hit;
   logic [PAT_AW-1:0]     pat_rd_addr;
   logic [PALETTE_AW-1:0] pal_rd_addr;

   assign advance     = ~v2_ff | rsp.ready;
   assign pat_hit     = ({1'b0, load.addr} < (ADDR_W+1)'(PAT_DEPTH));
   assign pal_hit     = (load.addr < ADDR_W'(PAL_DEPTH));
   assign pat_rd_addr = {code_ff, idx_ff};
   assign pal_rd_addr = {set_ff, pat_q_ff};

   always_comb begin
      busy_in = busy_ff;
      run_in  = run_ff;
      idx_in  = idx_ff;
      v1_in   = v1_ff;
      v2_in   = v2_ff;
      if (advance) begin
         v1_in = run_ff;
         v2_in = v1_ff;
         if (run_ff) begin
            idx_in = idx_ff + 1'b1;
            if (&idx_ff) begin
               run_in = 1'b0;
            end
         end
      end
      if (v2_ff && rsp.ready && last_ff) begin
         busy_in = 1'b0;
      end
      if (job.start) begin
         busy_in = 1'b1;
         run_in  = 1'b1;
         idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         run_ff  <= 1'b0;
         idx_ff  <= '0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         run_ff  <= run_in;
         idx_ff  <= idx_in;
         v1_ff   <= v1_in;
         v2_ff   <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job.start) begin
         code_ff <= job.code[TILE_W-1:0];
         set_ff  <= job.set;
         col_ff  <= job.col;
         row_ff  <= job.row;
      end
   end

   // pattern store: load port and pixel read
   always_ff @(posedge clock) begin
      if (load.pat_we && pat_hit) begin
         pat_mem[load.addr[PAT_AW-1:0]] <= load.data[1:0];
      end
      if (advance) begin
         pat_q_ff <= pat_mem[pat_rd_addr];
         idx1_ff  <= idx_ff;
      end
   end

   // palette store; its read register is the output register
   always_ff @(posedge clock) begin
      if (load.pal_we && pal_hit) begin
         pal_mem[load.addr[PALETTE_AW-1:0]] <= load.data;
      end
      if (advance) begin
         pal_q_ff <= pal_mem[pal_rd_addr];
         x_ff     <= {col_ff, idx1_ff[5:3]};
         y_ff     <= {row_ff, idx1_ff[2:0]};
         last_ff  <= &idx1_ff;
      end
   end

   assign busy             = busy_ff;
   assign rsp.valid        = v2_ff;
   assign rsp.pixel_x      = x_ff;
   assign rsp.pixel_y      = y_ff;
   assign rsp.pixel_colour = pal_q_ff;
   assign rsp.last         = last_ff;

endmodule

`default_nettype wire

@@ tb/tile_video_renderer_unit_tb.sv @@
// Self-checking testbench for the tile video renderer: store preload, directed and random traffic.
module tile_video_renderer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tvr_pkg::*;

   // Request type that the block must drop without a trace.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam int TILE_LIMIT     = TILE_COUNT_DEFAULT;
   localparam int PATTERN_WORDS  = TILE_LIMIT * 64;
   localparam int PALETTE_WORDS  = 128;
   localparam int VIDEO_BYTES    = 2048;
   localparam int PIXELS_PER_TILE = 64;
   localparam int MAX_IDLE       = 18;
   localparam int HOLD_CYCLES    = 600;   // long pixel back-pressure stretch
   localparam int PHASE_ITEMS    = 80;    // four random phases, 320 requests in all
   localparam int USED_TILE_COUNT = 2;    // tiles with loaded patterns
   localparam int USED_SET_COUNT  = 4;    // palette sets that are loaded

   typedef struct {
      logic [7:0]  x;
      logic [8:0]  y;
      logic [15:0] colour;
      logic        last;
   } pixel_type;

   // Shadow of the three stores plus the queue of pixels still owed by the block.
   class tile_raster_model;
      logic [7:0]  video_mem   [VIDEO_BYTES];
      logic [1:0]  pattern_mem [PATTERN_WORDS];
      logic [15:0] palette_mem [PALETTE_WORDS];
      pixel_type   owed_pixels [$];
      int          mismatches;
      int          tiles_drawn;
      int          loads_taken;
      int          dropped;
      int          pixels_checked;

      function new();
         foreach (video_mem[i]) video_mem[i] = 8'h00;
         mismatches     = 0;
         tiles_drawn    = 0;
         loads_taken    = 0;
         dropped        = 0;
         pixels_checked = 0;
      endfunction

      function int owed();
         return owed_pixels.size();
      endfunction

      // Screen cell of a folded tile address; anything off the map lands at 0,0.
      function void locate_tile(input logic [9:0] a, output int col, output int row);
         int ai;
         ai  = a;
         col = 0;
         row = 0;
         if (ai >= 'h002 && ai <= 'h01d) begin
            col = 29 - ai;
            row = 34;
         end else if (ai >= 'h022 && ai <= 'h03d) begin
            col = 61 - ai;
            row = 35;
         end else if (ai >= 'h040 && ai <= 'h3bf) begin
            col = 27 - (ai - 'h040) / 32;
            row = 2 + (ai - 'h040) % 32;
         end else if (ai >= 'h3c2 && ai <= 'h3df) begin
            col = 27 - (ai - 'h3c2);
            row = 0;
         end else if (ai >= 'h3e2 && ai <= 'h3ff) begin
            col = 27 - (ai - 'h3e2);
            row = 1;
         end
      endfunction

      function void take_request(input logic [1:0] kind, input logic [13:0] a,
                                 input logic [15:0] d);
         logic [10:0] va;
         logic [9:0]  fa;
         logic [4:0]  set;
         int          base;
         int          col;
         int          row;
         pixel_type   p;
         if (kind == REQ_PATTERN) begin
            if (a < PATTERN_WORDS) begin
               pattern_mem[a] = d[1:0];
               loads_taken++;
            end else begin
               dropped++;
            end
         end else if (kind == REQ_PALETTE) begin
            if (a < PALETTE_WORDS) begin
               palette_mem[a] = d;
               loads_taken++;
            end else begin
               dropped++;
            end
         end else if (kind == REQ_VIDEO) begin
            va = a[10:0];
            video_mem[va] = d[7:0];
            fa  = va[9:0];
            set = video_mem[{1'b1, fa}][4:0];
            base = (int'(video_mem[{1'b0, fa}]) % TILE_LIMIT) * PIXELS_PER_TILE;
            locate_tile(fa, col, row);
            for (int i = 0; i < PIXELS_PER_TILE; i++) begin
               p.x      = 8'((col * 8 + i / 8) & 'hff);
               p.y      = 9'((row * 8 + i % 8) & 'h1ff);
               p.colour = palette_mem[{set, pattern_mem[base + i]}];
               p.last   = (i == PIXELS_PER_TILE - 1);
               owed_pixels.push_back(p);
            end
            tiles_drawn++;
         end else begin
            dropped++;
         end
      endfunction

      function void match_pixel(input logic [7:0] x, input logic [8:0] y,
                                input logic [15:0] c, input logic l);
         pixel_type e;
         if (owed_pixels.size() == 0) begin
            $error("unexpected pixel transfer: x=%0d y=%0d colour=%h", x, y, c);
            mismatches++;
            return;
         end
         e = owed_pixels.pop_front();
         pixels_checked++;
         if (x !== e.x) begin
            $error("pixel_x: expected %0d, got %0d", e.x, x);
            mismatches++;
         end
         if (y !== e.y) begin
            $error("pixel_y: expected %0d, got %0d", e.y, y);
            mismatches++;
         end
         if (c !== e.colour) begin
            $error("pixel_colour: expected %h, got %h", e.colour, c);
            mismatches++;
         end
         if (l !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, l);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   tvr_req_if req_bus ();
   tvr_rsp_if rsp_bus ();

   tile_video_renderer_unit u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   tile_raster_model sb = new();

   int gap_max   = 0;    // sender idle cycles per transfer, upper bound
   int stall_max = 0;    // receiver idle cycles per pixel, upper bound
   bit hold_pending = 1'b0;

   always #5 clock = ~clock;

   // Tile codes whose patterns are loaded: the lowest and the highest.
   function automatic logic [7:0] used_tile(input int k);
      case (k)
         0:       return 8'h00;
         default: return 8'hff;
      endcase
   endfunction

   // Palette sets that are loaded, both ends of the range and their neighbors.
   function automatic logic [4:0] used_set(input int k);
      case (k)
         0:       return 5'd0;
         1:       return 5'd1;
         2:       return 5'd30;
         default: return 5'd31;
      endcase
   endfunction

   // Hard stop in case the block hangs.
   initial begin
      #40_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Pixel receiver: random stalls per pixel, plus one long hold on request.
   // Outputs are sampled right at the rising edge, before any NBA update.
   initial begin : pixel_sink
      int stall;
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready) && !hold_pending);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.match_pixel(rsp_bus.pixel_x, rsp_bus.pixel_y, rsp_bus.pixel_colour,
                           rsp_bus.last);
      end
   end

   // One request transfer; the model is updated at the accepting edge.
   task automatic send_request(input logic [1:0] kind, input logic [13:0] a,
                               input logic [15:0] d);
      int gap;
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.addr     <= a;
      req_bus.data     <= d;
      do @(posedge clock); while (!req_bus.ready);
      sb.take_request(kind, a, d);
   endtask

   // Stop offering and wait until every owed pixel has arrived.
   task automatic drain_pixels();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.owed() != 0) @(posedge clock);
   endtask

   // Mostly tile draws and loads, with some dropped traffic mixed in. Video
   // bytes stay within the loaded tiles and palette sets.
   task automatic send_random_item();
      int          pick;
      logic [1:0]  kind;
      logic [13:0] a;
      logic [15:0] d;
      pick = $urandom_range(0, 99);
      a    = 14'($urandom());
      d    = 16'($urandom());
      if (pick < 45) begin
         kind = REQ_VIDEO;
         if (pick < 35) a = a & 14'h07ff;   // mostly inside the store
         if (a[10])
            d[7:0] = {d[7:5], used_set($urandom_range(0, USED_SET_COUNT - 1))};
         else
            d[7:0] = used_tile($urandom_range(0, USED_TILE_COUNT - 1));
      end else if (pick < 70) begin
         kind = REQ_PATTERN;
      end else if (pick < 85) begin
         kind = REQ_PALETTE;
         a    = 14'($urandom_range(0, PALETTE_WORDS - 1));
      end else if (pick < 93) begin
         kind = REQ_PALETTE;
         a    = 14'($urandom_range(PALETTE_WORDS, 16383));
      end else begin
         kind = REQ_UNUSED;
      end
      send_request(kind, a, d);
   endtask

   initial begin : stimulus
      req_bus.valid    <= 1'b0;
      req_bus.req_type <= REQ_VIDEO;
      req_bus.addr     <= '0;
      req_bus.data     <= '0;
      reset            <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Load the palette sets and tile patterns that draws use, back to back;
      // every video byte written later stays within them, so no draw reads an
      // unwritten entry. The block's RAM clear after reset holds us off first.
      gap_max   = 0;
      stall_max = 0;
      for (int s = 0; s < USED_SET_COUNT; s++)
         for (int e = 0; e < 4; e++)
            send_request(REQ_PALETTE, {7'd0, used_set(s), 2'(e)}, 16'($urandom()));
      for (int t = 0; t < USED_TILE_COUNT; t++)
         for (int i = 0; i < PIXELS_PER_TILE; i++)
            send_request(REQ_PATTERN, {used_tile(t), 6'(i)}, 16'($urandom()));

      // Directed: every placement region and its edges, colour-half and
      // out-of-store addresses, dropped loads and the unused type.
      gap_max   = MAX_IDLE;
      stall_max = MAX_IDLE;
      send_request(REQ_VIDEO,   14'h0000, 16'h0000);   // off the map, tile 0
      send_request(REQ_VIDEO,   14'h0402, 16'hffff);   // colour byte, set 31
      send_request(REQ_VIDEO,   14'h0002, 16'h00ff);   // bottom status row, first
      send_request(REQ_VIDEO,   14'h001d, 16'hff00);   // bottom status row, last
      send_request(REQ_VIDEO,   14'h0022, 16'h00ff);
      send_request(REQ_VIDEO,   14'h003d, 16'h5a00);
      send_request(REQ_VIDEO,   14'h0040, 16'h00ff);   // playfield corner
      send_request(REQ_VIDEO,   14'h03bf, 16'h0000);   // playfield far corner
      send_request(REQ_VIDEO,   14'h03c2, 16'h00ff);   // top row
      send_request(REQ_VIDEO,   14'h03df, 16'h0000);   // top row, column wraps
      send_request(REQ_VIDEO,   14'h03e2, 16'h00ff);
      send_request(REQ_VIDEO,   14'h03ff, 16'h0000);
      send_request(REQ_VIDEO,   14'h001e, 16'h00ff);   // gap between status rows
      send_request(REQ_VIDEO,   14'h07ff, 16'h00e1);   // top of store, set 1, high bits set
      send_request(REQ_VIDEO,   14'h3fff, 16'hff5e);   // beyond store, folds down, set 30
      send_request(REQ_PALETTE, 14'h0080, 16'h1234);   // dropped
      send_request(REQ_PALETTE, 14'h3fff, 16'hffff);   // dropped
      send_request(REQ_UNUSED,  14'h3fff, 16'hffff);   // dropped
      send_request(REQ_PATTERN, 14'h3fff, 16'hffff);
      send_request(REQ_PATTERN, 14'h0000, 16'h0000);
      send_request(REQ_PALETTE, 14'h007f, 16'hffff);
      send_request(REQ_PALETTE, 14'h0000, 16'h0000);
      send_request(REQ_VIDEO,   14'h07ff, 16'h00ff);   // colour byte, set 31
      send_request(REQ_VIDEO,   14'h03ff, 16'h00ff);   // re-draw tile 255 with new entries
      drain_pixels();

      // Long pixel hold while draws keep coming: the request side must stall.
      gap_max      = 0;
      hold_pending = 1'b1;
      for (int i = 0; i < 6; i++)
         send_request(REQ_VIDEO, 14'($urandom_range(0, (VIDEO_BYTES / 2) - 1)),
                      {8'($urandom()), used_tile($urandom_range(0, USED_TILE_COUNT - 1))});
      drain_pixels();

      // Random phases with each mix of idling and no idling on both sides.
      for (int ph = 0; ph < 4; ph++) begin
         gap_max   = (ph == 0 || ph == 2) ? MAX_IDLE : 0;
         stall_max = (ph == 0 || ph == 3) ? MAX_IDLE : 0;
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_random_item();
         if (ph == 1) drain_pixels();   // full pause mid-run
      end

      drain_pixels();
      repeat (100) @(posedge clock);   // catch any stray pixels

      $display("Run covered %0d tile draws (%0d pixels checked), %0d store loads,",
               sb.tiles_drawn, sb.pixels_checked, sb.loads_taken);
      $display("%0d dropped requests, random idling and a %0d-cycle pixel hold.",
               sb.dropped, HOLD_CYCLES);
      if (sb.mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
